[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/tsgr_pkg.sv]
package tsgr_pkg;

    typedef struct packed {
        logic [47:0]        sample_time;
        logic signed [47:0] sample_value;
        logic               first_of_series;
    } sample_t;

    typedef struct packed {
        logic [47:0]        grid_time;
        logic signed [47:0] grid_value;
        logic               exact_hit;
        logic               last_of_run;
        logic               truncated;
    } point_t;

    // classified request handed from front to back
    typedef struct packed {
        logic               is_first;
        logic [47:0]        t;
        logic signed [47:0] v;
        logic [47:0]        dt;
        logic [48:0]        mag;
        logic               neg;
    } job_t;

    localparam logic [47:0]        TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0]        VMAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SUM_MAX  = 50'sh7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SUM_MIN  = -SUM_MAX - 50'sd1;

    // a + b clamped to the 48-bit signed range
    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [48:0] b);
        logic signed [49:0] s;
        s = $signed({a[47], a[47], a}) + $signed({b[48], b});
        if (s > SUM_MAX)
            return SUM_MAX[47:0];
        else if (s < SUM_MIN)
            return SUM_MIN[47:0];
        else
            return s[47:0];
    endfunction

endpackage

[sv/time_series_grid_resampler_core.sv]
// Grid resampler: turns time-ordered (time, value) samples into points on a
// regular grid of spacing grid_step, linearly interpolated, starting at the
// first timestamp of each series.
// Input channel sample_valid/sample_stall/sample: one request per sample.
// Output channel point_valid/point_stall/point: zero or more grid points per
// sample, in order; last_of_run marks the final point of a sample.
// Config: cfg_we/cfg_wdata write grid_step (0 acts as 1); write only when idle.
// Per sample: a series start goes through the first-point state. Other
// samples pass the slope multiply and the slope divider; if grid points are
// due, then the grid-count divider, the emit state for each point (at most
// MAX_FILL), the skip multiplier when a truncated run leaves a remainder,
// and a closing step. Backward timestamps drop in the front stage.
// The serial divider in the back end sets the rate; a two-entry request
// queue lets the front take samples while the back end works.
// Reset clears all series state and sets grid_step to 1.
// A stalled output holds its point; the back end waits on it and the queue
// then fills, raising sample_stall.
module time_series_grid_resampler_core #(
    parameter int MAX_FILL = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  tsgr_pkg::sample_t sample,
    output logic              point_valid,
    input  logic              point_stall,
    output tsgr_pkg::point_t  point
);
    import tsgr_pkg::*;

    logic [31:0] grid_step_reg;
    logic [31:0] step;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_empty;
    logic        q_full;
    job_t        f_job;
    job_t        q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_step_reg <= 32'd1;
        else if (cfg_we)
            grid_step_reg <= cfg_wdata;
    end

    // zero step behaves as one
    assign step         = (grid_step_reg == 32'd0) ? 32'd1 : grid_step_reg;
    assign sample_stall = q_full;

    tsgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample       (sample),
        .q_full       (q_full),
        .accept       (accept),
        .push         (push),
        .job          (f_job)
    );

    tsgr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && accept),
        .wdata (f_job),
        .pop   (pop),
        .rdata (q_job),
        .empty (q_empty),
        .full  (q_full)
    );

    tsgr_back #(
        .MAX_FILL (MAX_FILL)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .q_empty     (q_empty),
        .q_job       (q_job),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule

[sv/tsgr_front.sv]
module tsgr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  tsgr_pkg::sample_t sample,
    input  logic              q_full,
    output logic              accept,
    output logic              push,
    output tsgr_pkg::job_t    job
);
    import tsgr_pkg::*;

    logic               active_reg;
    logic [47:0]        pt_reg;
    logic signed [47:0] pv_reg;
    logic signed [48:0] d;
    logic               first;

    assign accept = sample_valid && !q_full;
    assign first  = sample.first_of_series || !active_reg;
    assign d      = $signed({sample.sample_value[47], sample.sample_value})
                  - $signed({pv_reg[47], pv_reg});

    always_comb
    begin
        job.is_first = first;
        job.t        = sample.sample_time;
        job.v        = sample.sample_value;
        job.dt       = sample.sample_time - pt_reg;
        job.neg      = d[48];
        job.mag      = d[48] ? 49'(-d) : 49'(d);
    end

    // backward or repeated timestamps only update history
    assign push = accept && (first || (sample.sample_time > pt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pt_reg     <= '0;
            pv_reg     <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            pt_reg     <= sample.sample_time;
            pv_reg     <= sample.sample_value;
        end
    end

endmodule

[sv/tsgr_queue.sv]
module tsgr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsgr_pkg::job_t wdata,
    input  logic           pop,
    output tsgr_pkg::job_t rdata,
    output logic           empty,
    output logic           full
);
    import tsgr_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign empty   = (cnt_reg == 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[sv/tsgr_back.sv]
`include "assert_macros.svh"

module tsgr_back #(
    parameter int MAX_FILL = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      step,
    input  logic             q_empty,
    input  tsgr_pkg::job_t   q_job,
    output logic             pop,
    output logic             point_valid,
    input  logic             point_stall,
    output tsgr_pkg::point_t point
);
    import tsgr_pkg::*;

    localparam int CW = (MAX_FILL > 1) ? $clog2(MAX_FILL) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_FILL - 1);
    localparam logic [49:0]   ACC_CAP  = 50'h8000_0000_0000;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FIRST = 4'd1;
    localparam logic [3:0] ST_MUL0  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_NDIV  = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_MULK  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0]         state_reg, state_next;
    job_t               job_reg, job_next;
    logic [47:0]        ngt_reg, ngt_next;
    logic signed [47:0] last_reg, last_next;
    logic [79:0]        prod_reg, prod_next;
    logic [63:0]        plo_reg, plo_next;
    logic [48:0]        phi_reg, phi_next;
    logic [47:0]        rem_reg, rem_next;
    logic [47:0]        q_reg, q_next;
    logic               sat_reg, sat_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic signed [47:0] inc_reg, inc_next;
    logic [47:0]        incmag_reg, incmag_next;
    logic [47:0]        nrem_reg, nrem_next;
    logic               tr_reg, tr_next;
    logic [CW-1:0]      emit_last_reg, emit_last_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [47:0]        gt_reg, gt_next;
    logic [48:0]        acc_reg, acc_next;
    logic               pv_reg, pv_next;
    point_t             pt_reg, pt_next;

    // shared restoring divider step
    logic [47:0] divisor;
    logic [48:0] rem_s;
    logic        ge;
    logic [48:0] rem_d;
    logic [47:0] q_d;
    logic [47:0] qmag;
    logic        slot_free;
    logic [48:0] tsum;
    logic [49:0] acc_s;
    logic [48:0] acc_d;
    logic signed [48:0] kadd;
    logic signed [47:0] ival;
    logic [47:0] kcount;

    assign divisor   = (state_reg == ST_DIV) ? job_reg.dt : {16'd0, step};
    assign rem_s     = {rem_reg, prod_reg[79]};
    assign ge        = rem_s >= {1'b0, divisor};
    assign rem_d     = ge ? (rem_s - {1'b0, divisor}) : rem_s;
    assign q_d       = {q_reg[46:0], ge};
    assign slot_free = !pv_reg || !point_stall;
    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign ival      = sat_add(last_reg, {inc_reg[47], inc_reg});
    assign kcount    = q_reg + 48'd1 - 48'(MAX_FILL);
    assign acc_s     = {acc_reg, 1'b0} + (prod_reg[79] ? {2'b0, incmag_reg} : 50'd0);
    assign acc_d     = (acc_s > ACC_CAP) ? ACC_CAP[48:0] : acc_s[48:0];

    always_comb
    begin
        qmag = (sat_next || q_d[47]) ? VMAX : q_d;
        if (job_reg.neg)
            kadd = -$signed(acc_d);
        else
            kadd = (acc_d > {1'b0, VMAX}) ? $signed({1'b0, VMAX}) : $signed(acc_d);
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        ngt_next       = ngt_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        inc_next       = inc_reg;
        incmag_next    = incmag_reg;
        nrem_next      = nrem_reg;
        tr_next        = tr_reg;
        emit_last_next = emit_last_reg;
        idx_next       = idx_reg;
        gt_next        = gt_reg;
        acc_next       = acc_reg;
        pv_next        = pv_reg && point_stall;
        pt_next        = pt_reg;
        tsum           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next   = q_job;
                    state_next = q_job.is_first ? ST_FIRST : ST_MUL0;
                end
            end
            ST_FIRST:
            begin
                if (slot_free)
                begin
                    pv_next     = 1'b1;
                    pt_next     = '{job_reg.t, job_reg.v, 1'b1, 1'b1, 1'b0};
                    last_next   = job_reg.v;
                    tsum        = {1'b0, job_reg.t} + {17'd0, step};
                    ngt_next    = tsum[48] ? TIME_MAX : tsum[47:0];
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL0:
            begin
                plo_next   = job_reg.mag[31:0] * step;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                phi_next   = 49'(job_reg.mag[48:32] * step);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                // product stays below 2^80
                prod_next  = {48'(phi_reg + {17'd0, plo_reg[63:32]}), plo_reg[31:0]};
                rem_next   = '0;
                q_next     = '0;
                sat_next   = 1'b0;
                cnt_next   = 7'd79;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                prod_next = {prod_reg[78:0], 1'b0};
                rem_next  = rem_d[47:0];
                q_next    = q_d;
                sat_next  = sat_reg || q_reg[46];
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    incmag_next = qmag;
                    inc_next    = job_reg.neg ? -$signed(qmag) : $signed(qmag);
                    if (ngt_reg > job_reg.t)
                        state_next = ST_IDLE;
                    else
                    begin
                        prod_next  = {job_reg.t - ngt_reg, 32'd0};
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = 7'd47;
                        state_next = ST_NDIV;
                    end
                end
            end
            ST_NDIV:
            begin
                prod_next = {prod_reg[78:0], 1'b0};
                rem_next  = rem_d[47:0];
                q_next    = q_d;
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    nrem_next = rem_d[47:0];
                    tr_next   = q_d >= 48'(MAX_FILL);
                    emit_last_next = (q_d >= 48'(MAX_FILL)) ? LAST_IDX : q_d[CW-1:0];
                    idx_next   = '0;
                    gt_next    = ngt_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    pv_next = 1'b1;
                    pt_next.grid_time   = gt_reg;
                    pt_next.exact_hit   = (gt_reg == job_reg.t);
                    pt_next.grid_value  = (gt_reg == job_reg.t) ? job_reg.v : ival;
                    pt_next.last_of_run = (idx_reg == emit_last_reg);
                    pt_next.truncated   = tr_reg;
                    last_next = (gt_reg == job_reg.t) ? job_reg.v : ival;
                    gt_next   = gt_reg + {16'd0, step};
                    idx_next  = idx_reg + CW'(1);
                    if (idx_reg == emit_last_reg)
                    begin
                        if (tr_reg && (nrem_reg != 48'd0))
                        begin
                            prod_next  = {kcount, 32'd0};
                            acc_next   = '0;
                            cnt_next   = 7'd47;
                            state_next = ST_MULK;
                        end
                        else
                            state_next = ST_FIN;
                    end
                end
            end
            ST_MULK:
            begin
                prod_next = {prod_reg[78:0], 1'b0};
                acc_next  = acc_d;
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    last_next  = sat_add(last_reg, kadd);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (tr_reg && (nrem_reg == 48'd0))
                    last_next = job_reg.v;
                tsum       = {1'b0, job_reg.t - nrem_reg} + {17'd0, step};
                ngt_next   = tsum[48] ? TIME_MAX : tsum[47:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pv_reg    <= 1'b0;
            ngt_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= pv_next;
            ngt_reg   <= ngt_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        prod_reg      <= prod_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        sat_reg       <= sat_next;
        cnt_reg       <= cnt_next;
        inc_reg       <= inc_next;
        incmag_reg    <= incmag_next;
        nrem_reg      <= nrem_next;
        tr_reg        <= tr_next;
        emit_last_reg <= emit_last_next;
        idx_reg       <= idx_next;
        gt_reg        <= gt_next;
        acc_reg       <= acc_next;
        pt_reg        <= pt_next;
    end

    assign point_valid = pv_reg;
    assign point       = pt_reg;

    `ASSERT_AT(a_rem_below_divisor,
        !((state_reg == ST_DIV) || (state_reg == ST_NDIV)) || (rem_reg < divisor),
        "divider remainder not below divisor")
    `ASSERT_AT(a_idx_in_run,
        (state_reg != ST_EMIT) || (idx_reg <= emit_last_reg),
        "emit index past end of run")
    `ASSERT_NEXT(a_point_not_past_sample,
        (state_reg == ST_EMIT) && slot_free,
        pt_reg.grid_time <= job_reg.t,
        "grid point beyond sample time")
    `ASSERT_AT(a_trunc_run_full,
        !((state_reg == ST_EMIT) && tr_reg) || (emit_last_reg == LAST_IDX),
        "truncated run shorter than fill limit")

endmodule

[verif/time_series_grid_resampler_core_tb.sv]
`timescale 1ns / 100ps

// Grid resampler testbench.
// Samples go in through a sender that works in bursts; grid points come out
// under a receiver that stalls on its own pattern, and once holds off long
// enough to back the block up into its input. Every accepted sample runs
// through a local predictor, and each point that comes out is compared with
// the oldest predicted one.
module time_series_grid_resampler_core_tb;
    import tsgr_pkg::*;

    localparam int MAX_FILL = 64;
    localparam int DRAIN_CYCLES = 400;   // covers a sample that emits nothing
    localparam logic signed [47:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VAL_MIN = 48'sh8000_0000_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        point_valid;
    logic        point_stall;
    point_t      point;

    time_series_grid_resampler_core #(.MAX_FILL(MAX_FILL)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Predicted points, oldest first.
    point_t pending_points[$];
    int     errors = 0;
    int     samples_taken = 0;
    int     burst_left = 0;

    // Predictor copy of the block's series state and its grid step.
    logic [31:0]        grid_step_q;
    logic [47:0]        next_grid_q;
    logic [47:0]        prev_time_q;
    logic signed [47:0] prev_value_q;
    logic signed [47:0] last_value_q;
    bit                 series_on_q;

    // Append a point to the expected list.
    function automatic void expect_point(input point_t p);
        pending_points.insert(pending_points.size(), p);
    endfunction

    // Clamp a wide signed sum to the 48-bit signed range.
    function automatic logic signed [47:0] clamp_value(input logic signed [127:0] x);
        if (x > 128'sh7FFF_FFFF_FFFF)
            return VAL_MAX;
        else if (x < -128'sh8000_0000_0000)
            return VAL_MIN;
        else
            return x[47:0];
    endfunction

    // Advance the predictor by one sample; keep=0 drops its points (they are
    // typed into the stimulus table instead).
    task automatic resample(input sample_t s, input bit keep);
        logic [63:0]         stp;
        logic [63:0]         n;
        logic [63:0]         emit;
        logic [63:0]         gt;
        logic [63:0]         tl;
        logic signed [48:0]  dv;
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic signed [47:0]  inc;
        logic signed [127:0] wide_inc;
        logic signed [127:0] skipped;
        bit                  trunc;
        bit                  last_exact;
        point_t              p;
        stp = (grid_step_q == 0) ? 64'd1 : 64'(grid_step_q);
        if (s.first_of_series || !series_on_q)
        begin
            p = '{s.sample_time, s.sample_value, 1'b1, 1'b1, 1'b0};
            if (keep)
                expect_point(p);
            last_value_q = s.sample_value;
            tl = 64'(s.sample_time) + stp;
            next_grid_q = (tl > 64'(TIME_MAX)) ? TIME_MAX : tl[47:0];
            prev_time_q = s.sample_time;
            prev_value_q = s.sample_value;
            series_on_q = 1'b1;
            return;
        end
        if (s.sample_time <= prev_time_q)
        begin
            prev_time_q = s.sample_time;
            prev_value_q = s.sample_value;
            return;
        end
        // slope per grid step, truncated toward zero, magnitude saturated
        dv = $signed({s.sample_value[47], s.sample_value})
             - $signed({prev_value_q[47], prev_value_q});
        mag = (dv < 0) ? 128'(-dv) : 128'(dv);
        quo = (mag * 128'(stp)) / 128'(s.sample_time - prev_time_q);
        if (quo > 128'(VMAX))
            quo = 128'(VMAX);
        inc = (dv < 0) ? -$signed(quo[47:0]) : $signed(quo[47:0]);
        prev_time_q = s.sample_time;
        prev_value_q = s.sample_value;
        if (next_grid_q > s.sample_time)
            return;
        n = 64'(s.sample_time - next_grid_q) / stp + 1;
        last_exact = (64'(s.sample_time - next_grid_q) % stp) == 0;
        trunc = n > MAX_FILL;
        emit = trunc ? 64'(MAX_FILL) : n;
        wide_inc = inc;
        for (logic [63:0] i = 0; i < emit; i++)
        begin
            gt = 64'(next_grid_q) + i * stp;
            if (gt == 64'(s.sample_time))
                last_value_q = s.sample_value;
            else
                last_value_q = clamp_value($signed(128'(signed'(last_value_q))) + wide_inc);
            p = '{gt[47:0], last_value_q, gt == 64'(s.sample_time), i + 1 == emit, trunc};
            if (keep)
                expect_point(p);
        end
        // skipped points still move the value along
        if (trunc)
        begin
            if (last_exact)
                last_value_q = s.sample_value;
            else
            begin
                skipped = clamp_value(wide_inc * $signed({64'd0, n - emit}));
                last_value_q = clamp_value($signed(128'(signed'(last_value_q))) + skipped);
            end
        end
        tl = 64'(next_grid_q) + (n - 1) * stp + stp;
        next_grid_q = (tl > 64'(TIME_MAX)) ? TIME_MAX : tl[47:0];
    endtask

    // Offer one request; return at the edge where it is taken.
    task automatic send_sample(input sample_t s, input bit keep);
        if (burst_left == 0)
        begin
            // gap of zero now and then keeps back-to-back stretches
            if ($urandom_range(0, 3) != 0)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 15);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        samples_taken++;
        resample(s, keep);
    endtask

    // Let everything drain, including samples that emit nothing.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [31:0] stp);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= stp;
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_step_q = stp;
    endtask

    // Directed table: either a step write or a sample; n_typed < 0 means the
    // predictor supplies the points, otherwise 0 or 1 point is typed here.
    typedef struct {
        bit          is_cfg;
        logic [31:0] stp;
        sample_t     s;
        int          n_typed;
        point_t      typed;
    } row_t;

    row_t rows[$];

    function automatic void add_row(input row_t r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic row_t cfg_row(input logic [31:0] stp);
        row_t r;
        r.is_cfg = 1'b1;
        r.stp = stp;
        r.s = '0;
        r.n_typed = 0;
        r.typed = '0;
        return r;
    endfunction

    function automatic row_t smp_row(input logic [47:0] t, input logic signed [47:0] v,
                                     input bit first, input int n_typed);
        row_t r;
        r.is_cfg = 1'b0;
        r.stp = '0;
        r.s = '{t, v, first};
        r.n_typed = n_typed;
        // a typed point is always the exact hit of the sample itself
        r.typed = '{t, v, 1'b1, 1'b1, 1'b0};
        return r;
    endfunction

    // Receiver: stall modes change every so often; one long hold-off once
    // the sender is well under way, so the request queue fills.
    int  stall_cycles = 0;
    int  stall_mode = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk)
    begin
        stall_cycles <= stall_cycles + 1;
        if (!hold_done && samples_taken >= 60)
        begin
            hold_done <= 1'b1;
            hold_left <= 800;
            point_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            point_stall <= 1'b1;
        end
        else
        begin
            if (stall_cycles % 150 == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: point_stall <= 1'b0;
                1: point_stall <= ($urandom_range(0, 9) < 3);
                default: point_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Point checker.
    always @(posedge clk)
    begin
        if (rst_n && point_valid && !point_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point expected none, actual t=%h v=%h ex=%b last=%b tr=%b",
                         $time, point.grid_time, point.grid_value, point.exact_hit,
                         point.last_of_run, point.truncated);
                errors++;
            end
            else
            begin
                if (point !== pending_points[0])
                begin
                    $display("%0t: point mismatch expected t=%h v=%h ex=%b last=%b tr=%b",
                             $time, pending_points[0].grid_time, pending_points[0].grid_value,
                             pending_points[0].exact_hit, pending_points[0].last_of_run,
                             pending_points[0].truncated);
                    $display("%0t:                  actual t=%h v=%h ex=%b last=%b tr=%b",
                             $time, point.grid_time, point.grid_value, point.exact_hit,
                             point.last_of_run, point.truncated);
                    errors++;
                end
                void'(pending_points.pop_front());
            end
        end
    end

    // Run limit.
    initial
    begin
        #(8 * 1_500_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [47:0]        t;
        logic signed [47:0] v;
        logic [31:0]        stp;
        logic [63:0]        stp_eff;
        logic [63:0]        dt;
        sample_t            s;
        int                 r;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sample_valid = 1'b0;
        sample = '0;
        grid_step_q = 32'd1;
        next_grid_q = '0;
        prev_time_q = '0;
        prev_value_q = '0;
        last_value_q = '0;
        series_on_q = 1'b0;

        // step 1 out of reset: series start, run, repeat, backward, truncation
        add_row(smp_row(48'd100, 48'sd5 <<< 16, 1'b1, 1));
        add_row(smp_row(48'd103, 48'sd8 <<< 16, 1'b0, -1));
        add_row(smp_row(48'd103, 48'sd9 <<< 16, 1'b0, 0));
        add_row(smp_row(48'd90, 48'sd1 <<< 16, 1'b0, 0));
        add_row(smp_row(48'd300, -(48'sd2 <<< 16), 1'b0, -1));
        add_row(smp_row(48'd301, 48'sd0, 1'b0, -1));
        // value extremes; the slope saturates
        add_row(smp_row(48'd0, VAL_MAX, 1'b1, 1));
        add_row(smp_row(48'd1, VAL_MIN, 1'b0, 1));
        // end of the time axis: the grid is held at the top
        add_row(smp_row(TIME_MAX - 1, 48'sd0, 1'b1, 1));
        add_row(smp_row(TIME_MAX, -48'sd1, 1'b0, 1));
        add_row(smp_row(TIME_MAX, 48'sd7, 1'b0, 0));
        // coarser grid: a sample between grid points emits nothing
        add_row(cfg_row(32'd3));
        add_row(smp_row(48'd1000, 48'sd0, 1'b1, 1));
        add_row(smp_row(48'd1002, 48'sd7 <<< 16, 1'b0, -1));
        add_row(smp_row(48'd1010, 48'sd1 <<< 16, 1'b0, -1));
        // zero step behaves as one
        add_row(cfg_row(32'd0));
        add_row(smp_row(48'd5, 48'sd0, 1'b1, 1));
        add_row(smp_row(48'd9, 48'sd4 <<< 16, 1'b0, -1));
        // widest step
        add_row(cfg_row(32'hFFFF_FFFF));
        add_row(smp_row(48'd0, VAL_MIN, 1'b1, 1));
        add_row(smp_row(48'h1_FFFF_FFFE, VAL_MAX, 1'b0, -1));
        add_row(smp_row(48'h5_0000_0000, 48'sd0, 1'b0, -1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_step(rows[i].stp);
            else
            begin
                send_sample(rows[i].s, rows[i].n_typed < 0);
                if (rows[i].n_typed == 1)
                    expect_point(rows[i].typed);
            end
        end

        // Random phases, one grid step each. Mostly well-formed series with
        // short advances; some repeats, backward steps, long jumps, restarts.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: stp = 32'd1;
                1: stp = $urandom_range(2, 20);
                2: stp = 32'd0;
                3: stp = 32'hFFFF_FFFF;
                4: stp = $urandom;
                5: stp = 32'd7;
                6: stp = $urandom_range(1, 1000);
                default: stp = 32'd2;
            endcase
            write_step(stp);
            stp_eff = (stp == 0) ? 64'd1 : 64'(stp);
            t = 48'({$urandom, $urandom});
            v = 48'({$urandom, $urandom});
            send_sample('{t, v, 1'b1}, 1'b1);
            for (int k = 0; k < 38; k++)
            begin
                r = $urandom_range(0, 99);
                s.first_of_series = 1'b0;
                if (r < 5)
                begin
                    s.first_of_series = 1'b1;
                    t = 48'({$urandom, $urandom});
                end
                else if (r < 12)
                    t = t - 48'($urandom_range(0, 3));
                else if (r < 16)
                    t = 48'(64'(t) + stp_eff * $urandom_range(65, 100));
                else
                begin
                    dt = stp_eff * $urandom_range(0, 3) + 64'($urandom) % stp_eff + 1;
                    t = 48'(64'(t) + dt);
                end
                if ($urandom_range(0, 9) == 0)
                    v = 48'({$urandom, $urandom});
                else
                    v = clamp_value($signed(128'(signed'(v)))
                                    + $signed(128'($urandom_range(0, 1 << 22)))
                                    - 128'sd2097152);
                s.sample_time = t;
                s.sample_value = v;
                send_sample(s, 1'b1);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/tsgr_pkg.sv
sv/tsgr_front.sv
sv/tsgr_queue.sv
sv/tsgr_back.sv
sv/time_series_grid_resampler_core.sv
verif/time_series_grid_resampler_core_tb.sv
